FILE: hdl/cau_pkg.sv
package cau_pkg;

  localparam int DW    = 16;
  localparam int FB    = 8;
  localparam int AW    = 3;
  localparam int PW    = 2 * DW;
  localparam int VW    = 2 * DW + 2;
  localparam int NUMW  = PW;
  localparam int DENW  = PW;
  localparam int QW    = DW;
  localparam int CW    = DENW + QW;
  localparam int NCELL = QW;

  localparam logic [AW-1:0] ACT_ADD  = 3'd0;
  localparam logic [AW-1:0] ACT_SUB  = 3'd1;
  localparam logic [AW-1:0] ACT_MUL  = 3'd2;
  localparam logic [AW-1:0] ACT_DIV  = 3'd3;
  localparam logic [AW-1:0] ACT_CONJ = 3'd4;

  typedef struct packed {
    logic                   neg;
    logic                   ovf;
    logic [DENW-1:0]        rem;
    logic [QW-1:0]          low;
    logic [QW-1:0]          q;
    logic signed [VW-1:0]   val;
  } lane_t;

  typedef struct packed {
    logic            div;
    logic [DENW-1:0] den;
    lane_t           re;
    lane_t           im;
  } cell_t;

endpackage

FILE: hdl/cau_if.sv
interface cau_in_if;
  logic                          valid;
  logic                          ready;
  logic [cau_pkg::AW-1:0]        action;
  logic signed [cau_pkg::DW-1:0] a_real;
  logic signed [cau_pkg::DW-1:0] a_imag;
  logic signed [cau_pkg::DW-1:0] b_real;
  logic signed [cau_pkg::DW-1:0] b_imag;

  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [cau_pkg::DW-1:0] res_real;
  logic signed [cau_pkg::DW-1:0] res_imag;
  logic                          saturated;

  modport source (output valid, res_real, res_imag, saturated, input ready);
  modport sink (input valid, res_real, res_imag, saturated, output ready);
endinterface

FILE: hdl/cau_front.sv
module cau_front (
  input  logic           clk,
  input  logic           rst,
  cau_in_if.sink         operand,
  output logic           out_valid,
  input  logic           out_ready,
  output cau_pkg::cell_t out_data
);

  logic                                s1_valid;
  logic                                s1_ready;
  logic [cau_pkg::AW-1:0]              s1_act;
  logic signed [cau_pkg::DW-1:0]       s1_ar, s1_ai, s1_br, s1_bi;
  logic signed [cau_pkg::PW-1:0]       s1_rr, s1_ii, s1_ri, s1_ir, s1_sr, s1_si;
  logic                                s2_ready;
  cau_pkg::cell_t                      s2_next;

  logic signed [cau_pkg::VW-1:0]       nr, ni, mr, mi;
  logic [cau_pkg::NUMW-1:0]            mag_r, mag_i;
  logic [cau_pkg::DENW-1:0]            den;
  logic [cau_pkg::NUMW+cau_pkg::FB-1:0] dvd_r, dvd_i;

  assign s2_ready      = !out_valid || out_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign operand.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= operand.valid;
    end
    if (s1_ready && operand.valid) begin
      s1_act <= operand.action;
      s1_ar  <= operand.a_real;
      s1_ai  <= operand.a_imag;
      s1_br  <= operand.b_real;
      s1_bi  <= operand.b_imag;
      s1_rr  <= operand.a_real * operand.b_real;
      s1_ii  <= operand.a_imag * operand.b_imag;
      s1_ri  <= operand.a_real * operand.b_imag;
      s1_ir  <= operand.a_imag * operand.b_real;
      s1_sr  <= operand.b_real * operand.b_real;
      s1_si  <= operand.b_imag * operand.b_imag;
    end
  end

  always_comb begin
    den   = cau_pkg::DENW'(unsigned'(s1_sr)) + cau_pkg::DENW'(unsigned'(s1_si));
    nr    = cau_pkg::VW'(s1_rr) + cau_pkg::VW'(s1_ii);
    ni    = cau_pkg::VW'(s1_ir) - cau_pkg::VW'(s1_ri);
    mr    = (cau_pkg::VW'(s1_rr) - cau_pkg::VW'(s1_ii)) >>> cau_pkg::FB;
    mi    = (cau_pkg::VW'(s1_ri) + cau_pkg::VW'(s1_ir)) >>> cau_pkg::FB;
    mag_r = nr[cau_pkg::VW-1] ? cau_pkg::NUMW'(-nr) : cau_pkg::NUMW'(nr);
    mag_i = ni[cau_pkg::VW-1] ? cau_pkg::NUMW'(-ni) : cau_pkg::NUMW'(ni);
    dvd_r = {mag_r, cau_pkg::FB'(0)};
    dvd_i = {mag_i, cau_pkg::FB'(0)};

    s2_next        = '0;
    s2_next.den    = den;
    s2_next.re.neg = nr[cau_pkg::VW-1];
    s2_next.im.neg = ni[cau_pkg::VW-1];
    s2_next.re.rem = cau_pkg::DENW'(dvd_r >> cau_pkg::QW);
    s2_next.im.rem = cau_pkg::DENW'(dvd_i >> cau_pkg::QW);
    s2_next.re.low = dvd_r[cau_pkg::QW-1:0];
    s2_next.im.low = dvd_i[cau_pkg::QW-1:0];
    s2_next.re.ovf = (cau_pkg::CW'(dvd_r)) >= (cau_pkg::CW'(den) << cau_pkg::QW);
    s2_next.im.ovf = (cau_pkg::CW'(dvd_i)) >= (cau_pkg::CW'(den) << cau_pkg::QW);
    case (s1_act)
      cau_pkg::ACT_ADD: begin
        s2_next.re.val = cau_pkg::VW'(s1_ar) + cau_pkg::VW'(s1_br);
        s2_next.im.val = cau_pkg::VW'(s1_ai) + cau_pkg::VW'(s1_bi);
      end
      cau_pkg::ACT_SUB: begin
        s2_next.re.val = cau_pkg::VW'(s1_ar) - cau_pkg::VW'(s1_br);
        s2_next.im.val = cau_pkg::VW'(s1_ai) - cau_pkg::VW'(s1_bi);
      end
      cau_pkg::ACT_MUL: begin
        s2_next.re.val = mr;
        s2_next.im.val = mi;
      end
      cau_pkg::ACT_DIV: begin
        s2_next.div = (den != '0);
      end
      cau_pkg::ACT_CONJ: begin
        s2_next.re.val = cau_pkg::VW'(s1_ar);
        s2_next.im.val = -cau_pkg::VW'(s1_ai);
      end
      default: begin
        s2_next.div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      out_data <= s2_next;
    end
  end

endmodule

FILE: hdl/cau_cell.sv
module cau_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::cell_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cau_pkg::cell_t out_data
);

  cau_pkg::cell_t data_next;
  logic [cau_pkg::DENW:0] t_re, t_im;
  logic                   b_re, b_im;

  assign in_ready = !out_valid || out_ready;

  // one restoring quotient bit per lane
  always_comb begin
    data_next = in_data;
    t_re = {in_data.re.rem, in_data.re.low[cau_pkg::QW-1]};
    t_im = {in_data.im.rem, in_data.im.low[cau_pkg::QW-1]};
    b_re = t_re >= {1'b0, in_data.den};
    b_im = t_im >= {1'b0, in_data.den};
    data_next.re.rem = b_re ? cau_pkg::DENW'(t_re - {1'b0, in_data.den})
                            : cau_pkg::DENW'(t_re);
    data_next.im.rem = b_im ? cau_pkg::DENW'(t_im - {1'b0, in_data.den})
                            : cau_pkg::DENW'(t_im);
    data_next.re.low = in_data.re.low << 1;
    data_next.im.low = in_data.im.low << 1;
    data_next.re.q   = {in_data.re.q[cau_pkg::QW-2:0], b_re};
    data_next.im.q   = {in_data.im.q[cau_pkg::QW-2:0], b_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: hdl/cau_back.sv
module cau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::cell_t in_data,
  cau_out_if.source      result
);

  localparam logic signed [cau_pkg::VW-1:0] VPOS =
    {{(cau_pkg::VW-cau_pkg::DW+1){1'b0}}, {(cau_pkg::DW-1){1'b1}}};
  localparam logic signed [cau_pkg::VW-1:0] VNEG =
    {{(cau_pkg::VW-cau_pkg::DW+1){1'b1}}, {(cau_pkg::DW-1){1'b0}}};
  localparam logic signed [cau_pkg::VW-1:0] VBIG = cau_pkg::VW'(1) << cau_pkg::DW;

  logic signed [cau_pkg::VW-1:0] v_re, v_im, c_re, c_im;
  logic                          f_re, f_im;

  function automatic logic signed [cau_pkg::VW-1:0] lane_val(input logic div,
                                                             input cau_pkg::lane_t l);
    logic signed [cau_pkg::VW-1:0] m;
    m = l.ovf ? VBIG : cau_pkg::VW'(l.q);
    if (!div) begin
      return l.val;
    end
    return l.neg ? -m : m;
  endfunction

  assign in_ready = !result.valid || result.ready;

  always_comb begin
    v_re = lane_val(in_data.div, in_data.re);
    v_im = lane_val(in_data.div, in_data.im);
    f_re = (v_re > VPOS) || (v_re < VNEG);
    f_im = (v_im > VPOS) || (v_im < VNEG);
    c_re = (v_re > VPOS) ? VPOS : ((v_re < VNEG) ? VNEG : v_re);
    c_im = (v_im > VPOS) ? VPOS : ((v_im < VNEG) ? VNEG : v_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (in_ready) begin
      result.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      result.res_real  <= c_re[cau_pkg::DW-1:0];
      result.res_imag  <= c_im[cau_pkg::DW-1:0];
      result.saturated <= f_re || f_im;
    end
  end

endmodule

FILE: hdl/complex_arithmetic_unit.sv
// Pipeline: 19 register stages (2 front stages, 16 divider cells, 1 output
// register); all actions take the same path. Throughput: one item per cycle
// while the output is not stalled; each divider cell resolves one quotient bit.
// Stages with a bubble keep accepting while the output is stalled.
// Reset (rst, synchronous, active high) clears all valid bits; no state else.
module complex_arithmetic_unit (
  input  logic      clk,
  input  logic      rst,
  cau_in_if.sink    operand,
  cau_out_if.source result
);

  logic           c_valid [cau_pkg::NCELL+1];
  logic           c_ready [cau_pkg::NCELL+1];
  cau_pkg::cell_t c_data  [cau_pkg::NCELL+1];

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_data  (c_data[0])
  );

  for (genvar i = 0; i < cau_pkg::NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_data   (c_data[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_data  (c_data[i+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid[cau_pkg::NCELL]),
    .in_ready (c_ready[cau_pkg::NCELL]),
    .in_data  (c_data[cau_pkg::NCELL]),
    .result   (result)
  );

endmodule

FILE: hdl/cau_checker.sv
module cau_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [cau_pkg::DW-1:0] res_real,
  input logic signed [cau_pkg::DW-1:0] res_imag,
  input logic                          saturated
);

  localparam logic signed [cau_pkg::DW-1:0] SPOS = {1'b0, {(cau_pkg::DW-1){1'b1}}};
  localparam logic signed [cau_pkg::DW-1:0] SNEG = {1'b1, {(cau_pkg::DW-1){1'b0}}};

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag)
      && $stable(saturated))
    else $error("stalled item changed");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> res_real == SPOS || res_real == SNEG
      || res_imag == SPOS || res_imag == SNEG)
    else $error("saturated item without a clipped part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .res_real  (result.res_real),
  .res_imag  (result.res_imag),
  .saturated (result.saturated)
);
